// File: design/dsiga_pkg.sv
// dsiga_pkg.sv: shared types, field layouts and address codes for the serial front end
`timescale 1ns / 1ps

package dsiga_pkg;

  localparam int InTdataWidth  = 40;
  localparam int InTuserWidth  = 2;
  localparam int OutTdataWidth = 32;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_PORT0 = 2'd1,
    SRC_PORT1 = 2'd2
  } irq_src_t;

  localparam logic [7:0] ADDR_SOFT_LATCH = 8'h60;
  localparam logic [7:0] ADDR_DIAG       = 8'h63;
  localparam logic [7:0] ADDR_CTRL_66    = 8'h66;
  localparam logic [7:0] ADDR_DATA_0     = 8'h67;
  localparam logic [7:0] ADDR_DATA_1     = 8'h68;
  localparam logic [7:0] ADDR_CTRL_69    = 8'h69;
  localparam logic [7:0] ADDR_STATUS_6A  = 8'h6a;
  localparam logic [7:0] ADDR_STATUS_A0  = 8'ha0;

  localparam logic [7:0] UNMAPPED_READ   = 8'hff;
  localparam logic [7:0] DIAG_IRQ_MASK   = 8'hfc;

  typedef struct packed {
    logic       irq1_seen;
    logic [7:0] pic_word;
    logic [7:0] rx_byte;
    logic       rx_port;
    logic [7:0] write_data;
    logic [7:0] address;
    kind_t      kind;
  } in_item_t;

  typedef struct packed {
    logic       pic_word_select;
    logic [7:0] tx_byte;
    logic       tx_port;
    logic       tx_valid;
    logic       nmi_enable;
    logic       nmi_pulse;
    logic [7:0] diag_irq_lines;
    logic       irq1_request;
    logic [7:0] read_data;
  } out_item_t;

endpackage

// File: design/dual_serial_input_gate_array_core.sv
// dual_serial_input_gate_array_core.sv: top level with input register and result register
`timescale 1ns / 1ps

// Bus and serial front end for two serial interfaces behind data registers 67h and 68h.
// Each input transfer is one event (bus read, bus write, received byte or poll tick,
// selected by tuser) and yields exactly one result transfer. The block takes one event
// per cycle while the result side is not stalling; each event passes through the input
// register and then the result register, with all register and interrupt logic
// evaluated in the single combinational step between them. Either side may stall freely.
module dual_serial_input_gate_array_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // address, write_data, rx_port, rx_byte, pic_word, irq1_seen, zero fill
  input  logic [dsiga_pkg::InTdataWidth-1:0]   s_axis_tdata,
  // kind
  input  logic [dsiga_pkg::InTuserWidth-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // read_data, irq1_request, diag_irq_lines, nmi_pulse, nmi_enable, tx_valid,
  // tx_port, tx_byte, pic_word_select, zero fill
  output logic [dsiga_pkg::OutTdataWidth-1:0]  m_axis_tdata
);
  import dsiga_pkg::*;

  logic      in_valid;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  out_item_t result;
  logic      step;

  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.kind       <= kind_t'(s_axis_tuser);
      in_item.address    <= s_axis_tdata[7:0];
      in_item.write_data <= s_axis_tdata[15:8];
      in_item.rx_port    <= s_axis_tdata[16];
      in_item.rx_byte    <= s_axis_tdata[24:17];
      in_item.pic_word   <= s_axis_tdata[32:25];
      in_item.irq1_seen  <= s_axis_tdata[33];
    end
  end

  dsiga_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutTdataWidth - $bits(out_item_t)){1'b0}}, out_item};

endmodule

// File: design/dsiga_core.sv
// dsiga_core.sv: register file, receive latches and interrupt logic, one item per step
`timescale 1ns / 1ps

module dsiga_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  dsiga_pkg::in_item_t item,
  output dsiga_pkg::out_item_t result
);
  import dsiga_pkg::*;

  logic [7:0] software_latch, software_latch_next;
  logic [7:0] diag_register, diag_register_next;
  logic [7:0] control_66, control_66_next;
  logic [7:0] control_69, control_69_next;
  logic [7:0] diag_irqs, diag_irqs_next;
  logic [1:0] tx_armed, tx_armed_next;
  logic [7:0] rx_latch [2];
  logic [7:0] rx_latch_next [2];
  logic [1:0] rx_full, rx_full_next;
  logic [1:0] rx_new, rx_new_next;
  irq_src_t   int_source, int_source_next;
  logic       irq1_level, irq1_level_next;
  logic       nmi_enable_latch, nmi_enable_latch_next;

  logic [1:0] ack;
  logic       nmi;
  logic [7:0] rd;
  logic       txv, txp;
  logic [7:0] txb;

  always_comb begin
    software_latch_next   = software_latch;
    diag_register_next    = diag_register;
    control_66_next       = control_66;
    control_69_next       = control_69;
    diag_irqs_next        = diag_irqs;
    tx_armed_next         = tx_armed;
    rx_latch_next         = rx_latch;
    rx_full_next          = rx_full;
    rx_new_next           = rx_new;
    int_source_next       = int_source;
    irq1_level_next       = irq1_level;
    nmi_enable_latch_next = nmi_enable_latch;
    ack = 2'b00;
    nmi = 1'b0;
    rd  = 8'h00;
    txv = 1'b0;
    txp = 1'b0;
    txb = 8'h00;

    unique case (item.kind)
      KIND_READ: begin
        unique case (item.address)
          ADDR_SOFT_LATCH: rd = software_latch;
          ADDR_DIAG:       rd = item.pic_word;
          ADDR_CTRL_66:    rd = control_66 | 8'h04;
          ADDR_DATA_0:     rd = rx_latch[0];
          ADDR_DATA_1:     rd = rx_latch[1];
          ADDR_CTRL_69:    rd = control_69;
          ADDR_STATUS_6A:  rd = {2'b00, rx_full[0], 2'b00, rx_full[1], 2'b00};
          ADDR_STATUS_A0:  rd = {4'h0, rx_full[1], rx_full[0], 2'b00};
          default:         rd = UNMAPPED_READ;
        endcase
      end
      KIND_WRITE: begin
        unique case (item.address)
          ADDR_SOFT_LATCH: software_latch_next = item.write_data;
          ADDR_DIAG: begin
            if (control_69[7]) begin
              diag_irqs_next = item.write_data & DIAG_IRQ_MASK;
              nmi = control_69[2] & ~diag_register[0] & item.write_data[0];
            end
            diag_register_next = item.write_data;
          end
          ADDR_CTRL_66: begin
            // rising edges on bits 4 and 6 acknowledge the receive latches
            ack[0] = ~control_66[4] & item.write_data[4];
            ack[1] = ~control_66[6] & item.write_data[6];
            control_66_next = item.write_data & 8'hfb;
          end
          ADDR_DATA_0, ADDR_DATA_1: begin
            txp = item.address[0] ? 1'b0 : 1'b1;
            if (tx_armed[txp]) begin
              txv = 1'b1;
              txb = item.write_data;
              tx_armed_next[txp] = 1'b0;
            end else begin
              txp = 1'b0;
            end
          end
          ADDR_CTRL_69: begin
            if (~control_69[3] & item.write_data[3]) tx_armed_next[0] = 1'b1;
            if (~control_69[4] & item.write_data[4]) tx_armed_next[1] = 1'b1;
            if (control_69[7] & ~item.write_data[7]) diag_irqs_next = 8'h00;
            control_69_next = item.write_data;
          end
          ADDR_STATUS_A0: nmi_enable_latch_next = item.write_data[7];
          default: ;
        endcase
      end
      KIND_RX: begin
        if (!rx_full[item.rx_port]) begin
          rx_latch_next[item.rx_port] = item.rx_byte;
          rx_full_next[item.rx_port]  = 1'b1;
          rx_new_next[item.rx_port]   = 1'b1;
        end
      end
      KIND_TICK: begin
        if ((|rx_full) && (int_source == SRC_NONE || (|rx_new) || !item.irq1_seen)) begin
          int_source_next = rx_full[1] ? SRC_PORT1 : SRC_PORT0;
          irq1_level_next = 1'b1;
        end
        rx_new_next = 2'b00;
      end
      default: ;
    endcase

    // acknowledging an empty latch does nothing
    if ((ack & rx_full) != 2'b00) begin
      rx_full_next = rx_full & ~ack;
      rx_new_next  = rx_new & ~ack;
      if (int_source != SRC_NONE) begin
        irq1_level_next = 1'b0;
        int_source_next = SRC_NONE;
      end
    end

    result.read_data       = rd;
    result.irq1_request    = irq1_level_next;
    result.diag_irq_lines  = diag_irqs_next;
    result.nmi_pulse       = nmi;
    result.nmi_enable      = nmi_enable_latch_next;
    result.tx_valid        = txv;
    result.tx_port         = txp;
    result.tx_byte         = txb;
    result.pic_word_select = control_69_next[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      software_latch   <= 8'h00;
      diag_register    <= 8'h00;
      control_66       <= 8'h00;
      control_69       <= 8'h00;
      diag_irqs        <= 8'h00;
      tx_armed         <= 2'b00;
      rx_latch[0]      <= 8'h00;
      rx_latch[1]      <= 8'h00;
      rx_full          <= 2'b00;
      rx_new           <= 2'b00;
      int_source       <= SRC_NONE;
      irq1_level       <= 1'b0;
      nmi_enable_latch <= 1'b1;
    end else if (step) begin
      software_latch   <= software_latch_next;
      diag_register    <= diag_register_next;
      control_66       <= control_66_next;
      control_69       <= control_69_next;
      diag_irqs        <= diag_irqs_next;
      tx_armed         <= tx_armed_next;
      rx_latch         <= rx_latch_next;
      rx_full          <= rx_full_next;
      rx_new           <= rx_new_next;
      int_source       <= int_source_next;
      irq1_level       <= irq1_level_next;
      nmi_enable_latch <= nmi_enable_latch_next;
    end
  end

endmodule

// File: test/dsiga_result_checker.sv
// dsiga_result_checker.sv: scoreboard that predicts and checks every result transfer
`timescale 1ns / 1ps

module dsiga_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [dsiga_pkg::InTdataWidth-1:0]  s_axis_tdata,
  input  logic [dsiga_pkg::InTuserWidth-1:0]  s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [dsiga_pkg::OutTdataWidth-1:0] m_axis_tdata,
  output int                                  fail_count,
  output int                                  results_owed
);
  import dsiga_pkg::*;

  localparam logic [7:0] CTRL66_READ_ONE = 8'h04;

  // predicted block state
  logic [7:0] soft_latch_q;
  logic [7:0] diag_reg_q;
  logic [7:0] ctrl66_q;
  logic [7:0] ctrl69_q;
  logic [7:0] diag_lines_q;
  logic [1:0] tx_arm_q;
  logic [7:0] rx_data_q [2];
  logic [1:0] rx_full_q;
  logic [1:0] rx_fresh_q;
  irq_src_t   irq_src_q;
  logic       irq1_q;
  logic       nmi_en_q;

  out_item_t owed_results [$];
  int        errs = 0;
  int        owed_count = 0;

  assign fail_count   = errs;
  assign results_owed = owed_count;

  function automatic logic [7:0] bus_view(input logic [7:0] addr, input logic [7:0] picw);
    case (addr)
      ADDR_SOFT_LATCH: return soft_latch_q;
      ADDR_DIAG:       return picw;
      ADDR_CTRL_66:    return ctrl66_q | CTRL66_READ_ONE;
      ADDR_DATA_0:     return rx_data_q[0];
      ADDR_DATA_1:     return rx_data_q[1];
      ADDR_CTRL_69:    return ctrl69_q;
      ADDR_STATUS_6A:  return {2'b00, rx_full_q[0], 2'b00, rx_full_q[1], 2'b00};
      ADDR_STATUS_A0:  return {4'h0, rx_full_q[1], rx_full_q[0], 2'b00};
      default:         return UNMAPPED_READ;
    endcase
  endfunction

  // acknowledging an empty latch leaves everything alone
  task automatic release_rx(input int p);
    if (rx_full_q[p]) begin
      rx_full_q[p]  = 1'b0;
      rx_fresh_q[p] = 1'b0;
      if (irq_src_q != SRC_NONE) begin
        irq1_q    = 1'b0;
        irq_src_q = SRC_NONE;
      end
    end
  endtask

  task automatic apply_event(input kind_t kind, input logic [7:0] addr, input logic [7:0] wdata,
                             input logic rxp, input logic [7:0] rxb, input logic [7:0] picw,
                             input logic seen, output out_item_t res);
    logic port_sel;
    res = '0;
    case (kind)
      KIND_READ: res.read_data = bus_view(addr, picw);
      KIND_WRITE: begin
        case (addr)
          ADDR_SOFT_LATCH: soft_latch_q = wdata;
          ADDR_DIAG: begin
            if (ctrl69_q[7]) begin
              diag_lines_q = wdata & DIAG_IRQ_MASK;
              // nmi fires on a rising bit 0, regardless of the nmi enable
              if (ctrl69_q[2] && !diag_reg_q[0] && wdata[0]) res.nmi_pulse = 1'b1;
            end
            diag_reg_q = wdata;
          end
          ADDR_CTRL_66: begin
            if (!ctrl66_q[4] && wdata[4]) release_rx(0);
            if (!ctrl66_q[6] && wdata[6]) release_rx(1);
            ctrl66_q = wdata & ~CTRL66_READ_ONE;
          end
          ADDR_DATA_0, ADDR_DATA_1: begin
            port_sel = (addr == ADDR_DATA_1);
            if (tx_arm_q[port_sel]) begin
              res.tx_valid = 1'b1;
              res.tx_port  = port_sel;
              res.tx_byte  = wdata;
              tx_arm_q[port_sel] = 1'b0;
            end
          end
          ADDR_CTRL_69: begin
            if (!ctrl69_q[3] && wdata[3]) tx_arm_q[0] = 1'b1;
            if (!ctrl69_q[4] && wdata[4]) tx_arm_q[1] = 1'b1;
            if (ctrl69_q[7] && !wdata[7]) diag_lines_q = '0;
            ctrl69_q = wdata;
          end
          ADDR_STATUS_A0: nmi_en_q = wdata[7];
          default: ;
        endcase
      end
      KIND_RX: begin
        // a byte into a full latch is dropped
        if (!rx_full_q[rxp]) begin
          rx_data_q[rxp]  = rxb;
          rx_full_q[rxp]  = 1'b1;
          rx_fresh_q[rxp] = 1'b1;
        end
      end
      default: begin
        if ((|rx_full_q) && (irq_src_q == SRC_NONE || (|rx_fresh_q) || !seen)) begin
          irq_src_q = rx_full_q[1] ? SRC_PORT1 : SRC_PORT0;
          irq1_q    = 1'b1;
        end
        rx_fresh_q = '0;
      end
    endcase
    res.irq1_request    = irq1_q;
    res.diag_irq_lines  = diag_lines_q;
    res.nmi_enable      = nmi_en_q;
    res.pic_word_select = ctrl69_q[6];
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      soft_latch_q = '0;
      diag_reg_q   = '0;
      ctrl66_q     = '0;
      ctrl69_q     = '0;
      diag_lines_q = '0;
      tx_arm_q     = '0;
      rx_data_q[0] = '0;
      rx_data_q[1] = '0;
      rx_full_q    = '0;
      rx_fresh_q   = '0;
      irq_src_q    = SRC_NONE;
      irq1_q       = 1'b0;
      nmi_en_q     = 1'b1;
      owed_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result transfer %h", m_axis_tdata);
          errs++;
        end else begin
          want = owed_results.pop_front();
          got  = out_item_t'(m_axis_tdata[$bits(out_item_t)-1:0]);
          check_field("read_data", want.read_data, got.read_data);
          check_field("irq1_request", want.irq1_request, got.irq1_request);
          check_field("diag_irq_lines", want.diag_irq_lines, got.diag_irq_lines);
          check_field("nmi_pulse", want.nmi_pulse, got.nmi_pulse);
          check_field("nmi_enable", want.nmi_enable, got.nmi_enable);
          check_field("tx_valid", want.tx_valid, got.tx_valid);
          check_field("tx_port", want.tx_port, got.tx_port);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("pic_word_select", want.pic_word_select, got.pic_word_select);
          check_field("zero_fill", 8'h00, 8'(m_axis_tdata[OutTdataWidth-1:$bits(out_item_t)]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_event(kind_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8],
                    s_axis_tdata[16], s_axis_tdata[24:17], s_axis_tdata[32:25],
                    s_axis_tdata[33], want);
        owed_results.push_back(want);
      end
    end
    owed_count <= owed_results.size();
  end

endmodule

// File: test/tb_dual_serial_input_gate_array_core.sv
// tb_dual_serial_input_gate_array_core.sv: stimulus and verdict for the serial front end
`timescale 1ns / 1ps

module tb_dual_serial_input_gate_array_core;
  import dsiga_pkg::*;

  localparam int RandomItems = 1150;
  localparam int DrainCycles = 10;

  localparam logic [7:0] ARM_PORT0   = 8'h08;
  localparam logic [7:0] ARM_PORT1   = 8'h10;
  localparam logic [7:0] ACK_PORT0   = 8'h10;
  localparam logic [7:0] ACK_PORT1   = 8'h40;
  localparam logic [7:0] DIAG_ENABLE = 8'h80;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // address, write_data, rx_port, rx_byte, pic_word, irq1_seen, zero fill
  logic [InTdataWidth-1:0]  s_axis_tdata = '0;
  // kind
  logic [InTuserWidth-1:0]  s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // read_data, irq1_request, diag_irq_lines, nmi_pulse, nmi_enable, tx_valid,
  // tx_port, tx_byte, pic_word_select, zero fill
  logic [OutTdataWidth-1:0] m_axis_tdata;

  int fail_count;
  int results_owed;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;

  always #5 clk = ~clk;

  dual_serial_input_gate_array_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dsiga_result_checker result_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_event(input kind_t kind, input logic [7:0] addr, input logic [7:0] wdata,
                            input logic rxp, input logic [7:0] rxb, input logic seen);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, seen, rnd8(), rxb, rxp, wdata, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // unused fields of each transfer carry random content
  task automatic bus_rd(input logic [7:0] addr);
    send_event(KIND_READ, addr, rnd8(), 1'($urandom_range(1)), rnd8(), 1'($urandom_range(1)));
  endtask

  task automatic bus_wr(input logic [7:0] addr, input logic [7:0] wdata);
    send_event(KIND_WRITE, addr, wdata, 1'($urandom_range(1)), rnd8(), 1'($urandom_range(1)));
  endtask

  task automatic serial_in(input logic port, input logic [7:0] data);
    send_event(KIND_RX, rnd8(), rnd8(), port, data, 1'($urandom_range(1)));
  endtask

  task automatic poll_tick(input logic seen);
    send_event(KIND_TICK, rnd8(), rnd8(), 1'($urandom_range(1)), rnd8(), seen);
  endtask

  function automatic logic [7:0] pick_addr();
    logic [7:0] mapped [8];
    mapped = '{ADDR_SOFT_LATCH, ADDR_DIAG, ADDR_CTRL_66, ADDR_DATA_0,
               ADDR_DATA_1, ADDR_CTRL_69, ADDR_STATUS_6A, ADDR_STATUS_A0};
    if ($urandom_range(7) == 0) return rnd8();
    return mapped[$urandom_range(7)];
  endfunction

  task automatic random_burst();
    logic [7:0] v;
    logic       p;
    int         pick;
    pick = $urandom_range(9);
    p    = 1'($urandom_range(1));
    v    = rnd8();
    case (pick)
      0, 1: begin
        send_event(kind_t'($urandom_range(3)), rnd8(), rnd8(), p, rnd8(),
                   1'($urandom_range(1)));
      end
      2, 3: begin
        // drop the arm bit, raise it, then write the data register
        bus_wr(ADDR_CTRL_69, v & ~(ARM_PORT0 | ARM_PORT1));
        bus_wr(ADDR_CTRL_69, v | (p ? ARM_PORT1 : ARM_PORT0));
        if ($urandom_range(3) == 0) bus_rd(pick_addr());
        bus_wr(p ? ADDR_DATA_1 : ADDR_DATA_0, rnd8());
      end
      4, 5, 6: begin
        serial_in(p, rnd8());
        if ($urandom_range(1)) serial_in(1'($urandom_range(1)), rnd8());
        poll_tick(1'($urandom_range(1)));
        if ($urandom_range(1)) poll_tick(1'($urandom_range(1)));
        bus_rd(p ? ADDR_DATA_1 : ADDR_DATA_0);
        bus_rd($urandom_range(1) ? ADDR_STATUS_6A : ADDR_STATUS_A0);
        bus_wr(ADDR_CTRL_66, v & ~(ACK_PORT0 | ACK_PORT1));
        if ($urandom_range(3) != 0) bus_wr(ADDR_CTRL_66, v | (p ? ACK_PORT1 : ACK_PORT0));
        else poll_tick(1'($urandom_range(1)));
      end
      7: begin
        bus_wr(ADDR_CTRL_69, v | DIAG_ENABLE);
        bus_wr(ADDR_DIAG, rnd8());
        bus_wr(ADDR_DIAG, rnd8());
        if ($urandom_range(1)) bus_wr(ADDR_CTRL_69, rnd8() & ~DIAG_ENABLE);
      end
      default: begin
        if ($urandom_range(1)) bus_rd(pick_addr());
        else bus_wr(pick_addr(), rnd8());
      end
    endcase
  endtask

  initial begin
    int directed_count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values of every register, plus both unmapped extremes
    bus_rd(ADDR_SOFT_LATCH);
    bus_rd(ADDR_DIAG);
    bus_rd(ADDR_CTRL_66);
    bus_rd(ADDR_DATA_0);
    bus_rd(ADDR_DATA_1);
    bus_rd(ADDR_CTRL_69);
    bus_rd(ADDR_STATUS_6A);
    bus_rd(ADDR_STATUS_A0);
    bus_rd(8'h00);
    bus_rd(8'hff);
    bus_wr(ADDR_SOFT_LATCH, 8'hff);
    bus_rd(ADDR_SOFT_LATCH);
    // arm both ports and enable diag drive; second write has no new edge
    bus_wr(ADDR_CTRL_69, 8'h98);
    bus_wr(ADDR_CTRL_69, 8'hdc);
    bus_wr(ADDR_DIAG, 8'hfd);
    bus_wr(ADDR_DATA_0, 8'h5a);
    bus_wr(ADDR_DATA_1, 8'ha5);
    bus_wr(ADDR_DATA_1, 8'h00);
    // second byte on port 0 lands in a full latch and is dropped
    serial_in(1'b0, 8'h00);
    serial_in(1'b0, 8'hff);
    serial_in(1'b1, 8'hff);
    poll_tick(1'b1);
    bus_rd(ADDR_STATUS_6A);
    bus_rd(ADDR_STATUS_A0);
    bus_wr(ADDR_CTRL_66, ACK_PORT0 | ACK_PORT1);
    bus_wr(ADDR_STATUS_A0, 8'h00);
    bus_wr(ADDR_STATUS_A0, 8'h80);
    bus_wr(ADDR_CTRL_69, 8'h00);
    bus_wr(8'h00, 8'hff);
    directed_count = items_sent;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 21 : 0;
      recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 21 : 0;
      while (items_sent < directed_count + (ph + 1) * RandomItems / 4) random_burst();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
